// ===== hw/rtl/response_frame_checker_unit_defines.svh =====
// assertion macros shared by the response frame checker rtl
`ifndef RESPONSE_FRAME_CHECKER_UNIT_DEFINES_SVH
`define RESPONSE_FRAME_CHECKER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define RFC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfc assertion failed");

// next-cycle implication, disabled during reset
`define RFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfc assertion failed");

`else

`define RFC_ASSERT_NOW(label, clk, rst, ante, cons)
`define RFC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/rfc_pkg.sv =====
// types, codes and constants of the response frame checker
`default_nettype none

package rfc_pkg;

   // window and frame geometry
   localparam int DEFAULT_WINDOW_BYTES = 256;
   localparam int MIN_FRAME_BYTES      = 6;
   localparam int DATA_START_OFFSET    = 5;
   localparam int OFFSET_W             = 9;
   localparam int BYTE_W               = 8;
   localparam int STATUS_W             = 3;
   localparam int CSR_INDEX_W          = 2;

   // configuration register defaults
   localparam logic [BYTE_W-1:0] RESET_HEADER_FIRST  = 8'd172;
   localparam logic [BYTE_W-1:0] RESET_HEADER_SECOND = 8'd183;
   localparam logic [BYTE_W-1:0] RESET_EXPECTED_PID  = 8'd0;
   localparam logic [BYTE_W-1:0] RESET_MAX_COPY_LEN  = 8'd255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEADER_FIRST  = 2'd0,
      CSR_HEADER_SECOND = 2'd1,
      CSR_EXPECTED_PID  = 2'd2,
      CSR_MAX_COPY_LEN  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PHASE_HUNT = 3'd0,
      PHASE_HEAD = 3'd1,
      PHASE_DATA = 3'd2,
      PHASE_SUM  = 3'd3,
      PHASE_DONE = 3'd4
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 3'd0,
      STATUS_SHORT      = 3'd1,
      STATUS_NO_HEADER  = 3'd2,
      STATUS_PID        = 3'd3,
      STATUS_INCOMPLETE = 3'd4,
      STATUS_CHECKSUM   = 3'd5
   } status_type;

   typedef struct packed {
      logic              req_type;
      logic [BYTE_W-1:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic                is_status;
      logic [BYTE_W-1:0]   data_byte;
      logic [BYTE_W-1:0]   data_index;
      logic [STATUS_W-1:0] status;
   } rsp_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header_first;
      logic [BYTE_W-1:0] header_second;
      logic [BYTE_W-1:0] expected_pid;
      logic [BYTE_W-1:0] max_copy_len;
   } cfg_regs_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rfc_csr_regs.sv =====
// configuration registers of the response frame checker
`default_nettype none

module rfc_csr_regs
   import rfc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [BYTE_W-1:0]      csr_wdata,
   output cfg_regs_type                cfg
);

   cfg_regs_type cfg_ff;
   cfg_regs_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_HEADER_FIRST:  cfg_in.header_first  = csr_wdata;
            CSR_HEADER_SECOND: cfg_in.header_second = csr_wdata;
            CSR_EXPECTED_PID:  cfg_in.expected_pid  = csr_wdata;
            CSR_MAX_COPY_LEN:  cfg_in.max_copy_len  = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first  <= RESET_HEADER_FIRST;
         cfg_ff.header_second <= RESET_HEADER_SECOND;
         cfg_ff.expected_pid  <= RESET_EXPECTED_PID;
         cfg_ff.max_copy_len  <= RESET_MAX_COPY_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rfc_input_stage.sv =====
// input register of the response frame checker
`default_nettype none

module rfc_input_stage
   import rfc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_item,
   input  wire logic         advance_ready,
   output logic              held_valid,
   output req_item_type      held_item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   // hold the item while the core cannot move it on
   assign req_stall = valid_ff && !advance_ready;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rfc_frame_core.sv =====
// frame state and per-item checking logic of the response frame checker
`default_nettype none
`include "response_frame_checker_unit_defines.svh"

module rfc_frame_core
   import rfc_pkg::*;
#(
   parameter int WINDOW_BYTES = DEFAULT_WINDOW_BYTES
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_regs_type cfg,
   input  wire logic         fire,
   input  wire req_item_type item,
   output logic              res_valid,
   output rsp_item_type      res_item
);

   localparam int COUNT_W = $clog2(WINDOW_BYTES + 1);

   logic [COUNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0]   previous_byte_ff, previous_byte_in;
   logic [COUNT_W-1:0]  header_position_ff, header_position_in;
   phase_type           phase_ff, phase_in;
   logic [OFFSET_W-1:0] frame_offset_ff, frame_offset_in;
   logic [BYTE_W-1:0]   data_length_ff, data_length_in;
   logic [BYTE_W-1:0]   running_sum_ff, running_sum_in;
   status_type          outcome_ff, outcome_in;

   logic                in_window;
   logic                byte_fire;
   logic                end_fire;
   logic                header_seen;
   logic [OFFSET_W-1:0] offset_inc;
   logic [OFFSET_W-1:0] data_idx;
   logic [BYTE_W-1:0]   sum_with_byte;
   logic                last_data;
   logic [COUNT_W:0]    header_limit;
   status_type          final_status;
   logic                data_res;
   logic                window_idle;
   logic                outcome_legal;

   // shared terms
   assign in_window     = byte_count_ff < COUNT_W'(WINDOW_BYTES);
   assign byte_fire     = fire && !item.req_type && in_window;
   assign end_fire      = fire && item.req_type;
   assign header_seen   = (byte_count_ff != '0) && (previous_byte_ff == cfg.header_first)
                          && (item.rx_byte == cfg.header_second);
   assign offset_inc    = frame_offset_ff + OFFSET_W'(1);
   assign data_idx      = offset_inc - OFFSET_W'(DATA_START_OFFSET);
   assign sum_with_byte = running_sum_ff + item.rx_byte;
   assign last_data     = (data_idx + OFFSET_W'(1)) >= {1'b0, data_length_ff};
   assign header_limit  = {1'b0, header_position_ff} + (COUNT_W + 1)'(MIN_FRAME_BYTES);

   // verdict at the end of the window
   always_comb begin
      if (byte_count_ff < COUNT_W'(MIN_FRAME_BYTES)) begin
         final_status = STATUS_SHORT;
      end else if (phase_ff == PHASE_HUNT) begin
         final_status = STATUS_NO_HEADER;
      end else if (header_limit > {1'b0, byte_count_ff}) begin
         final_status = STATUS_NO_HEADER;
      end else if (outcome_ff == STATUS_PID) begin
         final_status = STATUS_PID;
      end else if (phase_ff != PHASE_DONE) begin
         final_status = STATUS_INCOMPLETE;
      end else begin
         final_status = outcome_ff;
      end
   end

   // frame phase next state
   always_comb begin
      phase_in = phase_ff;
      if (fire && item.req_type) begin
         phase_in = PHASE_HUNT;
      end else if (byte_fire) begin
         unique case (phase_ff)
            PHASE_HUNT: begin
               if (header_seen) phase_in = PHASE_HEAD;
            end
            PHASE_HEAD: begin
               if (offset_inc == OFFSET_W'(4)) begin
                  phase_in = (item.rx_byte == '0) ? PHASE_SUM : PHASE_DATA;
               end
            end
            PHASE_DATA: begin
               if (last_data) phase_in = PHASE_SUM;
            end
            PHASE_SUM:  phase_in = PHASE_DONE;
            default:    phase_in = phase_ff;
         endcase
      end
   end

   // datapath state and result
   always_comb begin
      byte_count_in      = byte_count_ff;
      previous_byte_in   = previous_byte_ff;
      header_position_in = header_position_ff;
      frame_offset_in    = frame_offset_ff;
      data_length_in     = data_length_ff;
      running_sum_in     = running_sum_ff;
      outcome_in         = outcome_ff;
      res_valid          = 1'b0;
      res_item           = '0;
      if (fire && item.req_type) begin
         res_valid          = 1'b1;
         res_item.is_status = 1'b1;
         res_item.status    = final_status;
         byte_count_in      = '0;
         previous_byte_in   = '0;
         header_position_in = '0;
         frame_offset_in    = '0;
         data_length_in     = '0;
         running_sum_in     = '0;
         outcome_in         = STATUS_OK;
      end else if (byte_fire) begin
         unique case (phase_ff)
            PHASE_HUNT: begin
               if (header_seen) begin
                  header_position_in = byte_count_ff - COUNT_W'(1);
                  frame_offset_in    = OFFSET_W'(1);
                  running_sum_in     = previous_byte_ff + item.rx_byte;
               end
            end
            PHASE_HEAD: begin
               frame_offset_in = offset_inc;
               running_sum_in  = sum_with_byte;
               if (offset_inc == OFFSET_W'(3) && item.rx_byte != cfg.expected_pid) begin
                  outcome_in = STATUS_PID;
               end
               if (offset_inc == OFFSET_W'(4)) begin
                  data_length_in = item.rx_byte;
               end
            end
            PHASE_DATA: begin
               frame_offset_in = offset_inc;
               running_sum_in  = sum_with_byte;
               if (data_idx < {1'b0, cfg.max_copy_len}) begin
                  res_valid           = 1'b1;
                  res_item.data_byte  = item.rx_byte;
                  res_item.data_index = data_idx[BYTE_W-1:0];
               end
            end
            PHASE_SUM: begin
               frame_offset_in = offset_inc;
               if (sum_with_byte != '0 && outcome_ff != STATUS_PID) begin
                  outcome_in = STATUS_CHECKSUM;
               end
            end
            default: begin
               frame_offset_in = frame_offset_ff;
            end
         endcase
         previous_byte_in = item.rx_byte;
         byte_count_in    = byte_count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff      <= '0;
         previous_byte_ff   <= '0;
         header_position_ff <= '0;
         phase_ff           <= PHASE_HUNT;
         frame_offset_ff    <= '0;
         data_length_ff     <= '0;
         running_sum_ff     <= '0;
         outcome_ff         <= STATUS_OK;
      end else begin
         byte_count_ff      <= byte_count_in;
         previous_byte_ff   <= previous_byte_in;
         header_position_ff <= header_position_in;
         phase_ff           <= phase_in;
         frame_offset_ff    <= frame_offset_in;
         data_length_ff     <= data_length_in;
         running_sum_ff     <= running_sum_in;
         outcome_ff         <= outcome_in;
      end
   end

   // terms for the checks
   assign data_res      = res_valid && !res_item.is_status;
   assign window_idle   = byte_count_ff == '0 && phase_ff == PHASE_HUNT
                          && outcome_ff == STATUS_OK;
   assign outcome_legal = outcome_ff == STATUS_OK || outcome_ff == STATUS_PID
                          || outcome_ff == STATUS_CHECKSUM;

   // checks
   `RFC_ASSERT_NOW(a_count_in_window, clock, reset, 1'b1, byte_count_ff <= COUNT_W'(WINDOW_BYTES))
   `RFC_ASSERT_NOW(a_data_only_in_data_phase, clock, reset, data_res, phase_ff == PHASE_DATA)
   `RFC_ASSERT_NEXT(a_window_cleared, clock, reset, end_fire, window_idle)
   `RFC_ASSERT_NOW(a_outcome_codes, clock, reset, 1'b1, outcome_legal)

endmodule

`default_nettype wire

// ===== hw/rtl/rfc_output_stage.sv =====
// result register of the response frame checker
`default_nettype none

module rfc_output_stage
   import rfc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         fire,
   input  wire logic         res_valid,
   input  wire rsp_item_type res_item,
   output logic              advance_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_item
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;
   logic         load;

   // free when empty or being taken this cycle
   assign advance_ready = !valid_ff || !rsp_stall;
   assign load          = fire && res_valid;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= res_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/response_frame_checker_unit.sv =====
// Response frame checker: header, pid, length and checksum check of one reply window.
// Flow: an accepted item waits in the input register, then passes the core into the result
// register once that register is free; its result (if any) is shown there with rsp_valid high.
// Throughput: one item per cycle; the input stalls only while the result register holds
// a result that rsp_stall keeps from leaving.
// Reset: synchronous, active high; clears the window state, empties both registers
// and loads the configuration registers with their defaults.
`default_nettype none
`include "response_frame_checker_unit_defines.svh"

module response_frame_checker_unit
   import rfc_pkg::*;
#(
   parameter int WINDOW_BYTES = DEFAULT_WINDOW_BYTES
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_item_type           req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_item_type                rsp_item,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [BYTE_W-1:0]      csr_wdata
);

   cfg_regs_type cfg;
   logic         advance_ready;
   logic         held_valid;
   req_item_type held_item;
   logic         fire;
   logic         res_valid;
   rsp_item_type res_item;

   // configuration registers
   rfc_csr_regs u_csr_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input register
   rfc_input_stage u_input_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_item      (req_item),
      .advance_ready (advance_ready),
      .held_valid    (held_valid),
      .held_item     (held_item)
   );

   // held item moves through the core when the result register is free
   assign fire = held_valid && advance_ready;

   rfc_frame_core #(
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_frame_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .fire      (fire),
      .item      (held_item),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   // result register
   rfc_output_stage u_output_stage (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .res_valid     (res_valid),
      .res_item      (res_item),
      .advance_ready (advance_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_item      (rsp_item)
   );

   // checks
   `RFC_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall, held_valid && rsp_valid && rsp_stall)

endmodule

`default_nettype wire

// ===== tb/response_frame_checker_unit_tb.sv =====
// self-checking testbench of the response frame checker: directed and random reply windows
`timescale 1ns / 100ps

module response_frame_checker_unit_tb;
   import rfc_pkg::*;

   localparam int          WINDOW        = DEFAULT_WINDOW_BYTES;
   localparam int unsigned RANDOM_ITEMS  = 600;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT   = 200000;

   // expected behaviour of one reply window, and the results still owed by the block
   class reply_window_board;
      cfg_regs_type  cfg;
      int unsigned   byte_count;
      int unsigned   header_pos;
      int unsigned   frame_off;
      logic [7:0]    prev_byte;
      logic [7:0]    data_len;
      logic [7:0]    run_sum;
      phase_type     phase;
      status_type    verdict;
      rsp_item_type  expected_replies[$];
      int unsigned   mismatches;
      int unsigned   data_checked;
      int unsigned   status_checked;

      function new();
         cfg.header_first  = RESET_HEADER_FIRST;
         cfg.header_second = RESET_HEADER_SECOND;
         cfg.expected_pid  = RESET_EXPECTED_PID;
         cfg.max_copy_len  = RESET_MAX_COPY_LEN;
         mismatches     = 0;
         data_checked   = 0;
         status_checked = 0;
         restart_window();
      endfunction

      function void restart_window();
         byte_count = 0;
         header_pos = 0;
         frame_off  = 0;
         prev_byte  = '0;
         data_len   = '0;
         run_sum    = '0;
         phase      = PHASE_HUNT;
         verdict    = STATUS_OK;
      endfunction

      function void set_register(csr_index_type idx, logic [7:0] value);
         case (idx)
            CSR_HEADER_FIRST:  cfg.header_first  = value;
            CSR_HEADER_SECOND: cfg.header_second = value;
            CSR_EXPECTED_PID:  cfg.expected_pid  = value;
            CSR_MAX_COPY_LEN:  cfg.max_copy_len  = value;
            default: ;
         endcase
      endfunction

      // verdict of the window, in order of precedence
      function status_type window_verdict();
         if (byte_count < MIN_FRAME_BYTES) return STATUS_SHORT;
         if (phase == PHASE_HUNT) return STATUS_NO_HEADER;
         if (header_pos > byte_count - MIN_FRAME_BYTES) return STATUS_NO_HEADER;
         if (verdict == STATUS_PID) return STATUS_PID;
         if (phase != PHASE_DONE) return STATUS_INCOMPLETE;
         return verdict;
      endfunction

      // advance the window state by one accepted item
      function void predict_item(req_item_type it);
         rsp_item_type reply;
         int unsigned  slot;
         logic [7:0]   rx;
         logic [7:0]   total;
         reply = '0;
         rx    = it.rx_byte;
         if (it.req_type) begin
            reply.is_status = 1'b1;
            reply.status    = window_verdict();
            expected_replies.push_back(reply);
            restart_window();
            return;
         end
         // bytes beyond the window are dropped
         if (byte_count >= WINDOW) return;
         case (phase)
            PHASE_HUNT: begin
               if (byte_count > 0 && prev_byte == cfg.header_first &&
                   rx == cfg.header_second) begin
                  header_pos = byte_count - 1;
                  phase      = PHASE_HEAD;
                  frame_off  = 1;
                  run_sum    = prev_byte + rx;
               end
            end
            PHASE_HEAD: begin
               frame_off++;
               run_sum = run_sum + rx;
               if (frame_off == 3 && rx != cfg.expected_pid) verdict = STATUS_PID;
               if (frame_off == 4) begin
                  data_len = rx;
                  phase    = (rx == 0) ? PHASE_SUM : PHASE_DATA;
               end
            end
            PHASE_DATA: begin
               frame_off++;
               run_sum = run_sum + rx;
               slot    = frame_off - DATA_START_OFFSET;
               if (slot < cfg.max_copy_len) begin
                  reply.data_byte  = rx;
                  reply.data_index = slot[7:0];
                  expected_replies.push_back(reply);
               end
               if (slot + 1 >= data_len) phase = PHASE_SUM;
            end
            PHASE_SUM: begin
               frame_off++;
               total = run_sum + rx;
               if (total != 0 && verdict != STATUS_PID) verdict = STATUS_CHECKSUM;
               phase = PHASE_DONE;
            end
            default: ;
         endcase
         prev_byte = rx;
         byte_count++;
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
         end
      endfunction

      // match one accepted result against the oldest one owed
      function void check_reply(rsp_item_type got);
         rsp_item_type want;
         if (expected_replies.size() == 0) begin
            $error("result with none owed: is_status %0d data_byte %0d status %0d",
                   got.is_status, got.data_byte, got.status);
            mismatches++;
            return;
         end
         want = expected_replies.pop_front();
         compare_field("is_status", 8'(want.is_status), 8'(got.is_status));
         compare_field("data_byte", want.data_byte, got.data_byte);
         compare_field("data_index", want.data_index, got.data_index);
         compare_field("status", 8'(want.status), 8'(got.status));
         if (want.is_status) status_checked++;
         else data_checked++;
      endfunction
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_item_type           req_item  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_item_type           rsp_item;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0]      csr_wdata = '0;

   reply_window_board board;
   logic [7:0]        window_bytes[$];
   int unsigned       sender_idle_pct = 0;
   int unsigned       recv_idle_pct   = 0;
   int unsigned       items_sent      = 0;
   int unsigned       windows_sent    = 0;
   int unsigned       cycle_count     = 0;

   response_frame_checker_unit #(
      .WINDOW_BYTES(WINDOW)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // random back-pressure on the result side
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // both handshakes sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.predict_item(req_item);
         if (rsp_valid && !rsp_stall) board.check_reply(rsp_item);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // offer one item, with random gaps before it, and hold it until taken
   task automatic send_item(input logic end_of_window, input logic [7:0] value);
      req_item_type it;
      it.req_type = end_of_window;
      it.rx_byte  = value;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   // all queued bytes, then the end-of-window item
   task automatic send_window();
      foreach (window_bytes[i]) send_item(1'b0, window_bytes[i]);
      send_item(1'b1, 8'($urandom));
      window_bytes.delete();
      windows_sent++;
   endtask

   // noise leans towards the first header byte so that false starts occur
   function automatic logic [7:0] noise_byte();
      return ($urandom_range(7) == 0) ? board.cfg.header_first : 8'($urandom);
   endfunction

   // lead-in noise, then header, id, pid, length, data and checksum
   task automatic build_frame(input int unsigned lead, input logic [7:0] pid,
                              input int unsigned len, input bit bad_sum);
      logic [7:0] sum;
      logic [7:0] b;
      repeat (lead) window_bytes.push_back(noise_byte());
      b = 8'($urandom);
      window_bytes.push_back(board.cfg.header_first);
      window_bytes.push_back(board.cfg.header_second);
      window_bytes.push_back(b);
      window_bytes.push_back(pid);
      window_bytes.push_back(len[7:0]);
      sum = board.cfg.header_first + board.cfg.header_second + b + pid + len[7:0];
      repeat (len) begin
         b = 8'($urandom);
         window_bytes.push_back(b);
         sum = sum + b;
      end
      b = -sum;
      if (bad_sum) b = b ^ 8'($urandom_range(255, 1));
      window_bytes.push_back(b);
   endtask

   // mostly well-formed frames, some noise, late headers and truncation
   task automatic build_random_window();
      int unsigned pick;
      int unsigned len;
      int unsigned lead;
      logic [7:0]  pid;
      pick = $urandom_range(99);
      if (pick < 10) begin
         repeat ($urandom_range(12)) window_bytes.push_back(noise_byte());
      end else if (pick < 16) begin
         // header pair too near the end to hold a frame
         repeat ($urandom_range(4)) window_bytes.push_back(noise_byte());
         window_bytes.push_back(board.cfg.header_first);
         window_bytes.push_back(board.cfg.header_second);
         repeat ($urandom_range(3)) window_bytes.push_back(8'($urandom));
      end else begin
         pid = ($urandom_range(9) == 0) ? 8'($urandom) : board.cfg.expected_pid;
         if ($urandom_range(19) == 0) len = $urandom_range(1) ? 255 : $urandom_range(254, 13);
         else len = $urandom_range(12);
         // a few frames straddle the end of the window
         lead = (pick < 19) ? WINDOW - $urandom_range(10, 2) : $urandom_range(4);
         build_frame(lead, pid, len, $urandom_range(7) == 0);
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(len + 5, 1)) window_bytes.pop_back();
         end else begin
            repeat ($urandom_range(3)) window_bytes.push_back(8'($urandom));
         end
      end
   endtask

   // block drained: nothing owed and the pipeline given time to empty
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (board.expected_replies.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      board.set_register(idx, value);
      @(negedge clock);
   endtask

   task automatic apply_settings(input cfg_regs_type c);
      write_register(CSR_HEADER_FIRST, c.header_first);
      write_register(CSR_HEADER_SECOND, c.header_second);
      write_register(CSR_EXPECTED_PID, c.expected_pid);
      write_register(CSR_MAX_COPY_LEN, c.max_copy_len);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      cfg_regs_type csr_plan[6];
      int unsigned  send_gap_pct[3];
      int unsigned  recv_gap_pct[3];
      int unsigned  target;
      int           ph;
      int           slot;

      board = new();
      send_gap_pct = '{32, 73, 0};
      recv_gap_pct = '{73, 32, 0};
      csr_plan[0] = {RESET_HEADER_FIRST, RESET_HEADER_SECOND, RESET_EXPECTED_PID,
                     RESET_MAX_COPY_LEN};
      csr_plan[1] = {8'h00, 8'h00, 8'hFF, 8'h00};
      csr_plan[2] = {8'hFF, 8'hFF, 8'h00, 8'h01};
      csr_plan[3] = {8'h55, 8'hAA, 8'h80, 8'h03};
      csr_plan[4] = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      csr_plan[5] = {8'hFF, 8'h00, 8'hFF, 8'hFF};

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      sender_idle_pct = send_gap_pct[0];
      recv_idle_pct   = recv_gap_pct[0];

      // directed: empty window, zero-length frame, wrong pid, header too late
      send_window();
      build_frame(0, board.cfg.expected_pid, 0, 1'b0);
      send_window();
      build_frame(0, ~board.cfg.expected_pid, 2, 1'b0);
      send_window();
      window_bytes = '{8'h00, board.cfg.header_first, board.cfg.header_second,
                       8'h01, 8'h02, 8'h03};
      send_window();

      // random windows over three idling patterns and six register settings
      for (ph = 0; ph < 3; ph++) begin
         sender_idle_pct = send_gap_pct[ph];
         recv_idle_pct   = recv_gap_pct[ph];
         for (slot = 0; slot < 2; slot++) begin
            wait_until_idle();
            apply_settings(csr_plan[2 * ph + slot]);
            target = items_sent + RANDOM_ITEMS / 6;
            if (ph == 1 && slot == 0) begin
               build_frame(WINDOW - $urandom_range(10, 2), board.cfg.expected_pid,
                           $urandom_range(12), 1'b0);
               send_window();
            end
            while (items_sent < target) begin
               build_random_window();
               send_window();
            end
         end
      end
      wait_until_idle();

      $display("sent %0d items in %0d reply windows across 6 register settings",
               items_sent, windows_sent);
      $display("checked %0d data bytes and %0d window verdicts",
               board.data_checked, board.status_checked);
      if (board.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
